/* design/tcts_pkg.sv */
package tcts_pkg;

  localparam int IDX_W = 4;

  typedef enum logic [2:0] {
    OP_SCHED   = 3'd0,
    OP_SET     = 3'd1,
    OP_CONSUME = 3'd2,
    OP_BOOST   = 3'd3,
    OP_RESTORE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_EVAL,
    ST_RELOAD
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             blocked;
    logic             pair_ok;
    logic             apply;
    logic             reload;
  } cmd_t;

endpackage

/* design/tick_credit_task_scheduler.sv */
// Credit scheduler over a row of task cells. One transaction at a time: start is taken
// while busy is low, and exactly one result follows as a single-cycle out_strobe pulse that
// the receiver cannot stall. Every action sweeps a token down the row of ENTRIES cells, one
// cell per cycle, through ST_APPLY, ST_SCAN and ST_EVAL, with out_strobe registered after
// ST_EVAL; a schedule that finds no ready entry with credit reloads zero-credit entries
// in ST_RELOAD and sweeps again. busy drops in the cycle out_strobe is shown.
module tick_credit_task_scheduler #(
  parameter int ENTRIES      = 16,
  parameter int CREDIT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_entry_index,
  input  logic [3:0]  in_second_index,
  input  logic [15:0] in_priority_value,
  input  logic        in_blocked_flag,
  output logic        out_strobe,
  output logic [3:0]  out_selected_entry,
  output logic        out_none_ready,
  output logic [15:0] out_selected_credit
);
  import tcts_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = CREDIT_WIDTH;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] cnt_r;
  logic          rescan_r;
  logic          none_r;
  logic [IW-1:0] current_r, current_nxt;
  logic [CW-1:0] boost_r;

  op_t           op_r;
  logic [3:0]    idx_a_r, idx_b_r;
  logic [CW-1:0] prio_r;
  logic          blk_r;
  logic          pair_ok_r;

  logic          out_strobe_r;
  logic [3:0]    out_entry_r;
  logic          out_none_r;
  logic [15:0]   out_credit_r;

  logic          accept;
  logic          do_apply, do_reload, go_reload, emit, first_eval;
  logic [CW-1:0] emit_credit;
  cmd_t          cmd;

  logic [CW-1:0] tok_best_val [ENTRIES];
  logic [IW-1:0] tok_best_idx [ENTRIES];
  logic          tok_any      [ENTRIES];
  logic [IW-1:0] tok_first    [ENTRIES];
  logic [CW-1:0] tok_cur_val  [ENTRIES];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == LAST) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = go_reload ? ST_RELOAD : ST_IDLE;
      ST_RELOAD: state_nxt = ST_SCAN;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    do_apply    = (state_r == ST_APPLY);
    do_reload   = (state_r == ST_RELOAD);
    first_eval  = (state_r == ST_EVAL) && (op_r == OP_SCHED) && !rescan_r;
    go_reload   = first_eval && (tok_best_val[ENTRIES-1] == '0);
    emit        = (state_r == ST_EVAL) && !go_reload;
    current_nxt = current_r;
    emit_credit = tok_cur_val[ENTRIES-1];
    if (first_eval) begin
      if (!go_reload) begin
        current_nxt = tok_best_idx[ENTRIES-1];
        emit_credit = tok_best_val[ENTRIES-1];
      end else if (tok_any[ENTRIES-1]) begin
        current_nxt = tok_first[ENTRIES-1];
      end
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = op_r;
    cmd.idx_a   = idx_a_r;
    cmd.idx_b   = idx_b_r;
    cmd.blocked = blk_r;
    cmd.pair_ok = pair_ok_r;
    cmd.apply   = do_apply;
    cmd.reload  = do_reload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rescan_r     <= 1'b0;
      none_r       <= 1'b0;
      current_r    <= '0;
      boost_r      <= CW'(16'd1000);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= (state_r == ST_SCAN) ? cnt_r + IW'(1) : '0;
      current_r    <= current_nxt;
      out_strobe_r <= emit;
      if (cfg_we) begin
        boost_r <= CW'(cfg_wdata);
      end
      if (accept) begin
        rescan_r <= 1'b0;
        none_r   <= 1'b0;
      end else if (go_reload) begin
        rescan_r <= 1'b1;
        none_r   <= !tok_any[ENTRIES-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op_t'(in_action);
      idx_a_r   <= in_entry_index;
      idx_b_r   <= in_second_index;
      prio_r    <= CW'(in_priority_value);
      blk_r     <= in_blocked_flag;
      pair_ok_r <= (32'(in_entry_index) < ENTRIES) && (32'(in_second_index) < ENTRIES);
    end
    if (emit) begin
      out_entry_r  <= 4'(current_nxt);
      out_none_r   <= rescan_r && none_r;
      out_credit_r <= 16'(emit_credit);
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_selected_entry  = out_entry_r;
  assign out_none_ready      = out_none_r;
  assign out_selected_credit = out_credit_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [CW-1:0] p_best_val;
    logic [IW-1:0] p_best_idx;
    logic          p_any;
    logic [IW-1:0] p_first;
    logic [CW-1:0] p_cur_val;

    if (i == 0) begin : g_head
      assign p_best_val = '0;
      assign p_best_idx = '0;
      assign p_any      = 1'b0;
      assign p_first    = '0;
      assign p_cur_val  = '0;
    end else begin : g_link
      assign p_best_val = tok_best_val[i-1];
      assign p_best_idx = tok_best_idx[i-1];
      assign p_any      = tok_any[i-1];
      assign p_first    = tok_first[i-1];
      assign p_cur_val  = tok_cur_val[i-1];
    end

    tcts_cell #(
      .ENTRIES     (ENTRIES),
      .CREDIT_WIDTH(CREDIT_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .prio         (prio_r),
      .boost        (boost_r),
      .cur          (current_r),
      .prev_best_val(p_best_val),
      .prev_best_idx(p_best_idx),
      .prev_any     (p_any),
      .prev_first   (p_first),
      .prev_cur_val (p_cur_val),
      .best_val_r   (tok_best_val[i]),
      .best_idx_r   (tok_best_idx[i]),
      .any_r        (tok_any[i]),
      .first_r      (tok_first[i]),
      .cur_val_r    (tok_cur_val[i])
    );
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held for more than one cycle");

  a_current_range: assert property (@(posedge clk) disable iff (!rst_n)
    current_r <= LAST)
    else $error("current entry beyond the table");

  a_none_only_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_none_ready) |-> (op_r == OP_SCHED))
    else $error("none_ready raised on a non-schedule transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_strobe_r))
    else $error("accepted transaction did not raise busy");

endmodule

/* design/tcts_cell.sv */
module tcts_cell #(
  parameter int ENTRIES      = 16,
  parameter int CREDIT_WIDTH = 16,
  parameter int IDX          = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcts_pkg::cmd_t                    cmd,
  input  logic [CREDIT_WIDTH-1:0]           prio,
  input  logic [CREDIT_WIDTH-1:0]           boost,
  input  logic [$clog2(ENTRIES)-1:0]        cur,
  input  logic [CREDIT_WIDTH-1:0]           prev_best_val,
  input  logic [$clog2(ENTRIES)-1:0]        prev_best_idx,
  input  logic                              prev_any,
  input  logic [$clog2(ENTRIES)-1:0]        prev_first,
  input  logic [CREDIT_WIDTH-1:0]           prev_cur_val,
  output logic [CREDIT_WIDTH-1:0]           best_val_r,
  output logic [$clog2(ENTRIES)-1:0]        best_idx_r,
  output logic                              any_r,
  output logic [$clog2(ENTRIES)-1:0]        first_r,
  output logic [CREDIT_WIDTH-1:0]           cur_val_r
);
  import tcts_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = CREDIT_WIDTH;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [CW-1:0] credit_r, credit_nxt;
  logic [CW-1:0] saved_r, saved_nxt;
  logic [CW-1:0] prio_r, prio_nxt;
  logic          blocked_r, blocked_nxt;

  logic          hit_a, hit_b, hit_cur, hit_pair;
  logic [CW:0]   gain;
  logic [CW:0]   diff;
  logic [CW-1:0] restored;
  logic          ready;

  assign hit_a    = (32'(cmd.idx_a) == IDX);
  assign hit_b    = (32'(cmd.idx_b) == IDX);
  assign hit_cur  = (cur == MY_IDX);
  assign hit_pair = cmd.pair_ok && (hit_a || hit_b);
  assign ready    = !blocked_r;

  // saved minus used-since-boost (saved + credit - boost), floored at zero and clamped to full scale
  assign gain = {1'b0, saved_r} + {1'b0, credit_r};
  always_comb begin
    diff = '0;
    if (gain > {1'b0, boost}) begin
      diff = gain - {1'b0, boost};
    end
    restored = diff[CW] ? {CW{1'b1}} : diff[CW-1:0];
  end

  always_comb begin
    credit_nxt  = credit_r;
    saved_nxt   = saved_r;
    prio_nxt    = prio_r;
    blocked_nxt = blocked_r;
    if (cmd.apply) begin
      case (cmd.op)
        OP_SET: begin
          if (hit_a) begin
            prio_nxt    = prio;
            credit_nxt  = prio;
            blocked_nxt = cmd.blocked;
          end
        end
        OP_CONSUME: begin
          if (hit_cur && credit_r != '0) begin
            credit_nxt = credit_r - CW'(1);
          end
        end
        OP_BOOST: begin
          if (hit_pair) begin
            saved_nxt  = credit_r;
            credit_nxt = boost;
          end
        end
        OP_RESTORE: begin
          if (hit_pair) begin
            credit_nxt = restored;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.reload && credit_r == '0) begin
      credit_nxt = prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r  <= '0;
      saved_r   <= '0;
      prio_r    <= '0;
      blocked_r <= 1'b1;
    end else begin
      credit_r  <= credit_nxt;
      saved_r   <= saved_nxt;
      prio_r    <= prio_nxt;
      blocked_r <= blocked_nxt;
    end
  end

  // scan token, one hop per cycle
  always_ff @(posedge clk) begin
    if (ready && credit_r > prev_best_val) begin
      best_val_r <= credit_r;
      best_idx_r <= MY_IDX;
    end else begin
      best_val_r <= prev_best_val;
      best_idx_r <= prev_best_idx;
    end
    any_r   <= prev_any || ready;
    first_r <= (!prev_any && ready) ? MY_IDX : prev_first;
    cur_val_r <= hit_cur ? credit_r : prev_cur_val;
  end

endmodule
